@@ src/kse_pkg.sv @@
// ----------------------------------------------------------------------------
// kse_pkg: shared types and constants for the key store
// Request codes, status codes, sequencer states and the request and response item layouts.
// ----------------------------------------------------------------------------
package kse_pkg;

	localparam int MaxEntriesDef = 16;
	localparam int KeyBitsDef    = 64;
	localparam int IdBitsDef     = 64;
	localparam int TimeBits      = 48;
	localparam int TtlBits       = 32;
	localparam int UseBits       = 16;
	localparam int ThreshBits    = 16;
	localparam logic [ThreshBits-1:0] ThreshReset = 16'd100;
	localparam logic [TimeBits-1:0]   TimeMax     = {TimeBits{1'b1}};
	localparam logic [UseBits-1:0]    UsesMax     = {UseBits{1'b1}};

	typedef enum logic [2:0] {
		REQ_GENERATE = 3'd0,
		REQ_GET      = 3'd1,
		REQ_ROTATE   = 3'd2,
		REQ_REVOKE   = 3'd3,
		REQ_INFO     = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EXPIRED   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_ACT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [63:0]         key_id;
		logic [63:0]         fresh_id;
		logic [63:0]         fresh_key;
		logic [TtlBits-1:0]  ttl;
		logic [TimeBits-1:0] now;
	} req_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [3:0]          entry_index;
		logic [63:0]         id_out;
		logic [63:0]         key_value;
		logic                entry_active;
		logic [UseBits-1:0]  use_count;
		logic [TimeBits-1:0] created_time;
		logic [TimeBits-1:0] expiry_time;
	} rsp_item_t;

endpackage

@@ src/kse_if.sv @@
// ----------------------------------------------------------------------------
// kse_if: valid/ready channel
// Carries one item of the given payload type.
// ----------------------------------------------------------------------------
interface kse_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/key_store_with_expiry_rotation.sv @@
// ----------------------------------------------------------------------------
// key_store_with_expiry_rotation: key table with expiry and rotation
// Entries sit in one RAM; a sequencer scans on lookups, then read-modify-writes where the request needs it.
// ----------------------------------------------------------------------------
//  channel   dir  type        handshake
//  req       in   req_item_t  valid/ready
//  rsp       out  rsp_item_t  valid/ready
//  cfg       in   16 bits     cfg_we
// One item at a time. A lookup reads one entry per cycle from the entry
// RAM and stops scanning on the first match. Reset clears the active
// flags and the entry count; RAM contents stay undefined. A result waits in
// its register while the next item is taken; the sequencer stalls only if
// that register is still full when the next result is ready.
module key_store_with_expiry_rotation #(
	parameter int MAX_ENTRIES = kse_pkg::MaxEntriesDef,
	parameter int KEY_BITS    = kse_pkg::KeyBitsDef,
	parameter int ID_BITS     = kse_pkg::IdBitsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kse_if.sink                             req,
	kse_if.source                           rsp,
	input  logic                            cfg_we,
	input  logic [kse_pkg::ThreshBits-1:0]  cfg_wdata
);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int TB = kse_pkg::TimeBits;
	localparam int UB = kse_pkg::UseBits;
	localparam int RW = ID_BITS + KEY_BITS + 2 * TB + UB;
	localparam logic [CW-1:0] Full = CW'(MAX_ENTRIES);

	typedef struct packed {
		logic [ID_BITS-1:0]  id;
		logic [KEY_BITS-1:0] key;
		logic [TB-1:0]       created;
		logic [TB-1:0]       expiry;
		logic [UB-1:0]       uses;
	} row_t;

	kse_pkg::state_t state_q, state_d;
	kse_pkg::req_item_t r_q;
	logic [kse_pkg::ThreshBits-1:0] thresh_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] scan_q;      // next entry whose read is issued
	logic [AW-1:0] hit_q;
	logic          found_q;
	logic          rd_pend_q;   // read data for scan_q-1 arrives this cycle
	row_t          row_q;
	kse_pkg::rsp_item_t res_q;  // result built in act, waits for the output
	kse_pkg::rsp_item_t out_q;
	logic          out_vld_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	row_t          wrow, rrow;
	logic [RW-1:0] rdata;
	logic [AW-1:0] last_a;
	logic          match;
	logic [ID_BITS-1:0] key_id_m;
	logic [TB:0]   exp_sum;
	logic [TB-1:0] exp_new;
	logic [UB-1:0] uses_inc;
	logic          expired;
	logic          lookup_act;
	kse_pkg::rsp_item_t rsp_d;

	kse_mem #(.Depth(1 << AW), .Width(RW)) u_mem (
		.clk, .we, .waddr, .wdata(wrow), .raddr, .rdata
	);
	assign rrow = row_t'(rdata);

	assign key_id_m = r_q.key_id[ID_BITS-1:0];
	assign last_a   = AW'(scan_q - CW'(1));
	assign lookup_act = (r_q.req_type == kse_pkg::REQ_INFO) || valid_q[last_a];
	assign match = rd_pend_q && !found_q && lookup_act && (rrow.id == key_id_m);
	assign raddr = AW'(scan_q);

	assign exp_sum = {1'b0, r_q.now} + (TB+1)'(r_q.ttl);
	assign exp_new = (r_q.ttl == '0) ? '0 : (exp_sum[TB] ? kse_pkg::TimeMax : exp_sum[TB-1:0]);
	assign uses_inc = (row_q.uses == kse_pkg::UsesMax) ? row_q.uses : row_q.uses + UB'(1);
	assign expired = (row_q.expiry != '0) && (r_q.now > row_q.expiry);

	assign req.ready = (state_q == kse_pkg::S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kse_pkg::S_IDLE: if (req.valid) begin
				state_d = (req.data.req_type == kse_pkg::REQ_GENERATE) ? kse_pkg::S_ACT
					: kse_pkg::S_SCAN;
			end
			kse_pkg::S_SCAN: if (match || (scan_q >= total_q)) state_d = kse_pkg::S_WAIT;
			kse_pkg::S_WAIT: state_d = kse_pkg::S_ACT;
			kse_pkg::S_ACT:  state_d = kse_pkg::S_OUT;
			kse_pkg::S_OUT:  if (!out_vld_q || rsp.ready) state_d = kse_pkg::S_IDLE;
			default:         state_d = kse_pkg::S_IDLE;
		endcase
	end

	// Write port and result in the act state.
	always_comb begin
		we    = 1'b0;
		waddr = hit_q;
		wrow  = row_q;
		rsp_d = '0;
		rsp_d.status = kse_pkg::ST_NOT_FOUND;
		if (state_q == kse_pkg::S_ACT) begin
			priority case (r_q.req_type)
				kse_pkg::REQ_GENERATE: begin
					if (total_q >= Full) begin
						rsp_d.status = kse_pkg::ST_FULL;
					end else begin
						we = 1'b1;
						waddr = AW'(total_q);
						wrow.id = r_q.fresh_id[ID_BITS-1:0];
						wrow.key = r_q.fresh_key[KEY_BITS-1:0];
						wrow.created = r_q.now;
						wrow.expiry = exp_new;
						wrow.uses = '0;
						rsp_d.status = kse_pkg::ST_OK;
						rsp_d.entry_index = 4'(total_q);
						rsp_d.id_out = 64'(r_q.fresh_id[ID_BITS-1:0]);
					end
				end
				kse_pkg::REQ_GET: if (found_q) begin
					rsp_d.entry_index = 4'(hit_q);
					if (expired) begin
						rsp_d.status = kse_pkg::ST_EXPIRED;
					end else begin
						we = 1'b1;
						rsp_d.status = kse_pkg::ST_OK;
						rsp_d.key_value = 64'(row_q.key);
						wrow.uses = uses_inc;
						if (thresh_q != '0 && uses_inc >= thresh_q) begin
							wrow.key = r_q.fresh_key[KEY_BITS-1:0];
							wrow.created = r_q.now;
							wrow.uses = '0;
						end
					end
				end
				kse_pkg::REQ_ROTATE: if (found_q) begin
					we = 1'b1;
					wrow.key = r_q.fresh_key[KEY_BITS-1:0];
					wrow.created = r_q.now;
					wrow.uses = '0;
					rsp_d.status = kse_pkg::ST_OK;
					rsp_d.entry_index = 4'(hit_q);
				end
				kse_pkg::REQ_REVOKE: if (found_q) begin
					we = 1'b1;
					wrow.key = '0;
					rsp_d.status = kse_pkg::ST_OK;
					rsp_d.entry_index = 4'(hit_q);
				end
				kse_pkg::REQ_INFO: if (found_q) begin
					rsp_d.status = kse_pkg::ST_OK;
					rsp_d.entry_index = 4'(hit_q);
					rsp_d.entry_active = valid_q[hit_q];
					rsp_d.use_count = row_q.uses;
					rsp_d.created_time = row_q.created;
					rsp_d.expiry_time = row_q.expiry;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kse_pkg::S_IDLE;
			thresh_q  <= kse_pkg::ThreshReset;
			valid_q   <= '0;
			total_q   <= '0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			rd_pend_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thresh_q <= cfg_wdata;
			if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				kse_pkg::S_IDLE: begin
					scan_q    <= '0;
					found_q   <= 1'b0;
					rd_pend_q <= 1'b0;
				end
				kse_pkg::S_SCAN: begin
					if (match) found_q <= 1'b1;
					if (match || scan_q >= total_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						scan_q    <= scan_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				kse_pkg::S_ACT: begin
					if (r_q.req_type == kse_pkg::REQ_GENERATE && total_q < Full) begin
						valid_q[AW'(total_q)] <= 1'b1;
						total_q <= total_q + CW'(1);
					end
					if (found_q && ((r_q.req_type == kse_pkg::REQ_REVOKE)
							|| (r_q.req_type == kse_pkg::REQ_GET && expired))) begin
						valid_q[hit_q] <= 1'b0;
					end
				end
				kse_pkg::S_OUT: if (!out_vld_q || rsp.ready) out_vld_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) r_q <= req.data;
		if (match) begin
			hit_q <= last_a;
			row_q <= rrow;
		end
		if (state_q == kse_pkg::S_ACT) res_q <= rsp_d;
		// output register loads only once the previous result has left
		if (state_q == kse_pkg::S_OUT && (!out_vld_q || rsp.ready)) out_q <= res_q;
	end

	// Found entry index stays inside the filled part of the table.
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kse_pkg::S_ACT && found_q) |-> (CW'(hit_q) < total_q))
		else $error("hit index beyond entry count");
	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= Full) else $error("entry count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kse_pkg::S_OUT && out_vld_q && !rsp.ready) |=> state_q == kse_pkg::S_OUT)
		else $error("result overwritten");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != kse_pkg::S_ACT) |=> $stable(total_q))
		else $error("entry count changed outside act");
endmodule

@@ src/kse_mem.sv @@
// ----------------------------------------------------------------------------
// kse_mem: entry storage
// Synchronous RAM with one write port and one read port, one entry row per word; read data is registered.
// ----------------------------------------------------------------------------
module kse_mem #(
	parameter int Depth = kse_pkg::MaxEntriesDef,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
